// ===== hw/rtl/epoch_civil_date_converter_core_assert.svh =====
// Assertion macros for the epoch/civil date converter core.
// Included by the top level; no other dependencies.
`ifndef EPOCH_CIVIL_DATE_CONVERTER_CORE_ASSERT_SVH
`define EPOCH_CIVIL_DATE_CONVERTER_CORE_ASSERT_SVH

// same-cycle implication
`define ECDC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ECDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ecdc_pkg.sv =====
// Shared types, constants and constant-divisor helpers for the
// epoch/civil date converter. No dependencies.
package ecdc_pkg;

   localparam int unsigned NUM_STAGES = 7;

   localparam logic REQ_EPOCH_TO_CIVIL = 1'b0;
   localparam logic REQ_CIVIL_TO_EPOCH = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [31:0] epoch_seconds;
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic        has_time;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] epoch_out;
      logic        date_only;
      logic [11:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic [4:0]  hour_out;
      logic [5:0]  minute_out;
      logic [2:0]  weekday;
   } rsp_payload_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [2:0]  weekday;
   } civil_fields_type;

   typedef struct packed {
      logic [31:0] epoch;
      logic        date_only;
   } epoch_fields_type;

   typedef logic [NUM_STAGES-1:0] stage_en_type;

   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
   localparam logic [17:0] DAYS_PER_ERA  = 18'd146097;
   localparam logic [19:0] SHIFT_TO_1970 = 20'd719468;
   localparam logic [19:0] ERA4_BASE     = 20'd584388;
   localparam logic [19:0] ERA5_BASE     = 20'd730485;
   localparam logic [17:0] LAST_DOE      = 18'd146096;
   localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
   localparam logic [8:0]  YEARS_PER_ERA = 9'd400;
   localparam logic [11:0] YEAR_ERA4     = 12'd1600;
   localparam logic [11:0] YEAR_ERA5     = 12'd2000;

   // reciprocal multipliers: M = ceil(2^S / d), S chosen so x_max * (d - 1) < 2^S
   localparam int unsigned DIV675_SHIFT   = 35;
   localparam int unsigned DIV7_SHIFT     = 19;
   localparam int unsigned DIV1460_SHIFT  = 28;
   localparam int unsigned DIV36524_SHIFT = 33;
   localparam int unsigned DIV365_SHIFT   = 26;
   localparam int unsigned DIV100_SHIFT   = 16;
   localparam int unsigned DIV400_SHIFT   = 22;
   localparam int unsigned DIV153_SHIFT   = 19;
   localparam int unsigned DIV5_SHIFT     = 13;
   localparam int unsigned DIV3600_SHIFT  = 29;
   localparam int unsigned DIV60_SHIFT    = 18;

   localparam logic [25:0] DIV675_MULT =
      26'(((64'd1 << DIV675_SHIFT) + 64'd674) / 64'd675);
   localparam logic [16:0] DIV7_MULT =
      17'(((64'd1 << DIV7_SHIFT) + 64'd6) / 64'd7);
   localparam logic [17:0] DIV1460_MULT =
      18'(((64'd1 << DIV1460_SHIFT) + 64'd1459) / 64'd1460);
   localparam logic [17:0] DIV36524_MULT =
      18'(((64'd1 << DIV36524_SHIFT) + 64'd36523) / 64'd36524);
   localparam logic [17:0] DIV365_MULT =
      18'(((64'd1 << DIV365_SHIFT) + 64'd364) / 64'd365);
   localparam logic [9:0] DIV100_MULT =
      10'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);
   localparam logic [13:0] DIV400_MULT =
      14'(((64'd1 << DIV400_SHIFT) + 64'd399) / 64'd400);
   localparam logic [11:0] DIV153_MULT =
      12'(((64'd1 << DIV153_SHIFT) + 64'd152) / 64'd153);
   localparam logic [10:0] DIV5_MULT =
      11'(((64'd1 << DIV5_SHIFT) + 64'd4) / 64'd5);
   localparam logic [17:0] DIV3600_MULT =
      18'(((64'd1 << DIV3600_SHIFT) + 64'd3599) / 64'd3600);
   localparam logic [12:0] DIV60_MULT =
      13'(((64'd1 << DIV60_SHIFT) + 64'd59) / 64'd60);

   // x < 2^25
   function automatic logic [15:0] div675(input logic [24:0] x);
      logic [50:0] prod;
      prod = 51'(x) * 51'(DIV675_MULT);
      return prod[DIV675_SHIFT +: 16];
   endfunction

   // x <= 49714
   function automatic logic [12:0] div7(input logic [15:0] x);
      logic [32:0] prod;
      prod = 33'(x) * 33'(DIV7_MULT);
      return prod[DIV7_SHIFT +: 13];
   endfunction

   // x <= 146096
   function automatic logic [6:0] div1460(input logic [17:0] x);
      logic [35:0] prod;
      prod = 36'(x) * 36'(DIV1460_MULT);
      return prod[DIV1460_SHIFT +: 7];
   endfunction

   // x <= 146096
   function automatic logic [2:0] div36524(input logic [17:0] x);
      logic [35:0] prod;
      prod = 36'(x) * 36'(DIV36524_MULT);
      return prod[DIV36524_SHIFT +: 3];
   endfunction

   // x <= 146096
   function automatic logic [8:0] div365(input logic [17:0] x);
      logic [35:0] prod;
      prod = 36'(x) * 36'(DIV365_MULT);
      return prod[DIV365_SHIFT +: 9];
   endfunction

   // x <= 399
   function automatic logic [1:0] div100(input logic [8:0] x);
      logic [18:0] prod;
      prod = 19'(x) * 19'(DIV100_MULT);
      return prod[DIV100_SHIFT +: 2];
   endfunction

   // x <= 9999
   function automatic logic [4:0] div400(input logic [13:0] x);
      logic [27:0] prod;
      prod = 28'(x) * 28'(DIV400_MULT);
      return prod[DIV400_SHIFT +: 5];
   endfunction

   // x <= 1827
   function automatic logic [3:0] div153(input logic [10:0] x);
      logic [22:0] prod;
      prod = 23'(x) * 23'(DIV153_MULT);
      return prod[DIV153_SHIFT +: 4];
   endfunction

   // x <= 1685
   function automatic logic [8:0] div5(input logic [10:0] x);
      logic [21:0] prod;
      prod = 22'(x) * 22'(DIV5_MULT);
      return prod[DIV5_SHIFT +: 9];
   endfunction

   // x < 86400
   function automatic logic [4:0] div3600(input logic [16:0] x);
      logic [34:0] prod;
      prod = 35'(x) * 35'(DIV3600_MULT);
      return prod[DIV3600_SHIFT +: 5];
   endfunction

   // x < 3600
   function automatic logic [5:0] div60(input logic [11:0] x);
      logic [24:0] prod;
      prod = 25'(x) * 25'(DIV60_MULT);
      return prod[DIV60_SHIFT +: 6];
   endfunction

endpackage

// ===== hw/rtl/ecdc_e2c.sv =====
// Epoch seconds to civil date/time datapath, NUM_STAGES register stages.
// Depends on ecdc_pkg; stage enables come from the top-level flow control.
module ecdc_e2c
   import ecdc_pkg::*;
(
   input  logic             clock,
   input  stage_en_type     en,
   input  logic [31:0]      epoch_seconds,
   output civil_fields_type fields
);

   // stage 1
   logic [31:0] e1_epoch_ff;
   logic [15:0] e1_days_ff, e1_days_in;

   // stage 2
   logic [31:0] e2_day_secs;
   logic [31:0] e2_rem_full;
   logic [19:0] e2_z;
   logic        e2_era5;
   logic [19:0] e2_doe_full;
   logic [15:0] e2_dayp4;
   logic [16:0] e2_rem_ff;
   logic [17:0] e2_doe_ff;
   logic        e2_era5_ff;
   logic [15:0] e2_dayp4_ff;
   logic [12:0] e2_q7_ff, e2_q7_in;

   // stage 3
   logic [15:0] e3_wd_full;
   logic [16:0] e3_rem_ff;
   logic [4:0]  e3_hour_ff, e3_hour_in;
   logic [17:0] e3_doe_ff;
   logic [6:0]  e3_q1460_ff, e3_q1460_in;
   logic [2:0]  e3_q36524_ff, e3_q36524_in;
   logic        e3_last_ff, e3_last_in;
   logic [2:0]  e3_wday_ff;
   logic        e3_era5_ff;

   // stage 4
   logic [17:0] e4_t;
   logic [16:0] e4_remh_full;
   logic [17:0] e4_doe_ff;
   logic [8:0]  e4_yoe_ff, e4_yoe_in;
   logic [11:0] e4_remh_ff;
   logic [4:0]  e4_hour_ff;
   logic [2:0]  e4_wday_ff;
   logic        e4_era5_ff;

   // stage 5
   logic [1:0]  e5_q100;
   logic [17:0] e5_year_days;
   logic [17:0] e5_doy_full;
   logic [5:0]  e5_minute_ff, e5_minute_in;
   logic [8:0]  e5_doy_ff;
   logic [11:0] e5_y_ff, e5_y_in;
   logic [4:0]  e5_hour_ff;
   logic [2:0]  e5_wday_ff;

   // stage 6
   logic [3:0]  e6_mp_ff, e6_mp_in;
   logic [8:0]  e6_doy_ff;
   logic [11:0] e6_y_ff;
   logic [4:0]  e6_hour_ff;
   logic [5:0]  e6_minute_ff;
   logic [2:0]  e6_wday_ff;

   // stage 7
   logic [8:0]       e7_dsub;
   logic [8:0]       e7_day_full;
   logic [3:0]       e7_month;
   civil_fields_type e7_fields_ff, e7_fields_in;

   assign e1_days_in = div675(epoch_seconds[31:7]);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         e1_epoch_ff <= epoch_seconds;
         e1_days_ff  <= e1_days_in;
      end
   end

   always_comb begin
      e2_day_secs = 32'(e1_days_ff) * 32'(SECS_PER_DAY);
      e2_rem_full = e1_epoch_ff - e2_day_secs;
      e2_z        = 20'(e1_days_ff) + SHIFT_TO_1970;
      e2_era5     = e2_z >= ERA5_BASE;
      e2_doe_full = e2_z - (e2_era5 ? ERA5_BASE : ERA4_BASE);
      e2_dayp4    = e1_days_ff + 16'd4;
      e2_q7_in    = div7(e2_dayp4);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         e2_rem_ff   <= e2_rem_full[16:0];
         e2_doe_ff   <= e2_doe_full[17:0];
         e2_era5_ff  <= e2_era5;
         e2_dayp4_ff <= e2_dayp4;
         e2_q7_ff    <= e2_q7_in;
      end
   end

   always_comb begin
      e3_hour_in   = div3600(e2_rem_ff);
      e3_q1460_in  = div1460(e2_doe_ff);
      e3_q36524_in = div36524(e2_doe_ff);
      e3_last_in   = e2_doe_ff == LAST_DOE;
      e3_wd_full   = e2_dayp4_ff - 16'(e2_q7_ff) * 16'd7;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         e3_rem_ff    <= e2_rem_ff;
         e3_hour_ff   <= e3_hour_in;
         e3_doe_ff    <= e2_doe_ff;
         e3_q1460_ff  <= e3_q1460_in;
         e3_q36524_ff <= e3_q36524_in;
         e3_last_ff   <= e3_last_in;
         e3_wday_ff   <= e3_wd_full[2:0];
         e3_era5_ff   <= e2_era5_ff;
      end
   end

   always_comb begin
      e4_t = e3_doe_ff - 18'(e3_q1460_ff) + 18'(e3_q36524_ff) - 18'(e3_last_ff);
      e4_yoe_in = div365(e4_t);
      e4_remh_full = e3_rem_ff - 17'(e3_hour_ff) * 17'(SECS_PER_HOUR);
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         e4_doe_ff  <= e3_doe_ff;
         e4_yoe_ff  <= e4_yoe_in;
         e4_remh_ff <= e4_remh_full[11:0];
         e4_hour_ff <= e3_hour_ff;
         e4_wday_ff <= e3_wday_ff;
         e4_era5_ff <= e3_era5_ff;
      end
   end

   always_comb begin
      e5_minute_in = div60(e4_remh_ff);
      e5_q100      = div100(e4_yoe_ff);
      e5_year_days = 18'(e4_yoe_ff) * 18'(DAYS_PER_YEAR) + 18'(e4_yoe_ff[8:2])
                     - 18'(e5_q100);
      e5_doy_full  = e4_doe_ff - e5_year_days;
      e5_y_in      = 12'(e4_yoe_ff) + (e4_era5_ff ? YEAR_ERA5 : YEAR_ERA4);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         e5_minute_ff <= e5_minute_in;
         e5_doy_ff    <= e5_doy_full[8:0];
         e5_y_ff      <= e5_y_in;
         e5_hour_ff   <= e4_hour_ff;
         e5_wday_ff   <= e4_wday_ff;
      end
   end

   assign e6_mp_in = div153(11'(e5_doy_ff) * 11'd5 + 11'd2);

   always_ff @(posedge clock) begin
      if (en[5]) begin
         e6_mp_ff     <= e6_mp_in;
         e6_doy_ff    <= e5_doy_ff;
         e6_y_ff      <= e5_y_ff;
         e6_hour_ff   <= e5_hour_ff;
         e6_minute_ff <= e5_minute_ff;
         e6_wday_ff   <= e5_wday_ff;
      end
   end

   // mp counts months from March
   always_comb begin
      e7_dsub     = div5(11'(e6_mp_ff) * 11'd153 + 11'd2);
      e7_day_full = e6_doy_ff - e7_dsub + 9'd1;
      e7_month    = (e6_mp_ff < 4'd10) ? e6_mp_ff + 4'd3 : e6_mp_ff - 4'd9;
      e7_fields_in.year    = e6_y_ff + 12'(e7_month <= 4'd2);
      e7_fields_in.month   = e7_month;
      e7_fields_in.day     = e7_day_full[4:0];
      e7_fields_in.hour    = e6_hour_ff;
      e7_fields_in.minute  = e6_minute_ff;
      e7_fields_in.weekday = e6_wday_ff;
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         e7_fields_ff <= e7_fields_in;
      end
   end

   assign fields = e7_fields_ff;

endmodule

// ===== hw/rtl/ecdc_c2e.sv =====
// Civil date/time to epoch seconds datapath with range checks,
// NUM_STAGES register stages. Depends on ecdc_pkg.
module ecdc_c2e
   import ecdc_pkg::*;
(
   input  logic             clock,
   input  stage_en_type     en,
   input  req_payload_type  req,
   output epoch_fields_type fields
);

   // stage 1
   logic        c1_md_ok;
   logic        c1_time_ok;
   logic        c1_jan_feb;
   logic        c1_y_neg;
   logic        c1_y_big;
   logic [6:0]  c1_mshift_full;
   logic        c1_ok_ff, c1_ok_in;
   logic        c1_date_only_ff, c1_date_only_in;
   logic [13:0] c1_y_ff, c1_y_in;
   logic [3:0]  c1_mshift_ff;
   logic [4:0]  c1_day_ff;
   logic [16:0] c1_tsec_ff, c1_tsec_in;

   // stage 2
   logic        c2_ok_ff;
   logic        c2_date_only_ff;
   logic [13:0] c2_y_ff;
   logic [4:0]  c2_era_ff, c2_era_in;
   logic [8:0]  c2_doy_ff, c2_doy_in;
   logic [16:0] c2_tsec_ff;

   // stage 3
   logic [13:0] c3_yoe_full;
   logic        c3_ok_ff;
   logic        c3_date_only_ff;
   logic [4:0]  c3_era_ff;
   logic [8:0]  c3_yoe_ff;
   logic [8:0]  c3_doy_ff;
   logic [16:0] c3_tsec_ff;

   // stage 4
   logic [1:0]  c4_q100;
   logic        c4_ok_ff;
   logic        c4_date_only_ff;
   logic [4:0]  c4_era_ff;
   logic [17:0] c4_doe_ff, c4_doe_in;
   logic [16:0] c4_tsec_ff;

   // stage 5
   logic [21:0] c5_sum;
   logic        c5_ok_ff;
   logic        c5_date_only_ff;
   logic        c5_days_ok_ff;
   logic [21:0] c5_days_ff;
   logic [16:0] c5_tsec_ff;

   // stage 6
   logic [39:0] c6_total;
   logic        c6_ok_ff, c6_ok_in;
   logic        c6_date_only_ff;
   logic [31:0] c6_total_ff;

   // stage 7
   epoch_fields_type c7_fields_ff, c7_fields_in;

   always_comb begin
      c1_md_ok   = req.month >= 7'd1 && req.month <= 7'd12 &&
                   req.day >= 7'd1 && req.day <= 7'd31;
      c1_time_ok = req.hour <= 7'd23 && req.minute <= 7'd59 && req.second <= 7'd60;
      c1_jan_feb = req.month <= 7'd2;
      c1_y_neg   = c1_jan_feb && req.year == 14'd0;
      // every year after 2106 overflows 32 bits
      c1_y_big   = req.year > 14'd2106;
      c1_ok_in   = c1_md_ok && (!req.has_time || c1_time_ok) && !c1_y_neg && !c1_y_big;
      c1_date_only_in = c1_md_ok && !req.has_time;
      c1_y_in    = req.year - 14'(c1_jan_feb);
      c1_mshift_full = c1_jan_feb ? req.month + 7'd9 : req.month - 7'd3;
      if (req.has_time) begin
         c1_tsec_in = 17'(req.hour) * 17'(SECS_PER_HOUR) +
                      17'(req.minute) * 17'(SECS_PER_MIN) + 17'(req.second);
      end else begin
         c1_tsec_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         c1_ok_ff        <= c1_ok_in;
         c1_date_only_ff <= c1_date_only_in;
         c1_y_ff         <= c1_y_in;
         c1_mshift_ff    <= c1_mshift_full[3:0];
         c1_day_ff       <= req.day[4:0];
         c1_tsec_ff      <= c1_tsec_in;
      end
   end

   always_comb begin
      c2_era_in = div400(c1_y_ff);
      c2_doy_in = div5(11'(c1_mshift_ff) * 11'd153 + 11'd2) + 9'(c1_day_ff) - 9'd1;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         c2_ok_ff        <= c1_ok_ff;
         c2_date_only_ff <= c1_date_only_ff;
         c2_y_ff         <= c1_y_ff;
         c2_era_ff       <= c2_era_in;
         c2_doy_ff       <= c2_doy_in;
         c2_tsec_ff      <= c1_tsec_ff;
      end
   end

   assign c3_yoe_full = c2_y_ff - 14'(c2_era_ff) * 14'(YEARS_PER_ERA);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         c3_ok_ff        <= c2_ok_ff;
         c3_date_only_ff <= c2_date_only_ff;
         c3_era_ff       <= c2_era_ff;
         c3_yoe_ff       <= c3_yoe_full[8:0];
         c3_doy_ff       <= c2_doy_ff;
         c3_tsec_ff      <= c2_tsec_ff;
      end
   end

   always_comb begin
      c4_q100   = div100(c3_yoe_ff);
      c4_doe_in = 18'(c3_yoe_ff) * 18'(DAYS_PER_YEAR) + 18'(c3_yoe_ff[8:2])
                  - 18'(c4_q100) + 18'(c3_doy_ff);
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         c4_ok_ff        <= c3_ok_ff;
         c4_date_only_ff <= c3_date_only_ff;
         c4_era_ff       <= c3_era_ff;
         c4_doe_ff       <= c4_doe_in;
         c4_tsec_ff      <= c3_tsec_ff;
      end
   end

   assign c5_sum = 22'(c4_era_ff) * 22'(DAYS_PER_ERA) + 22'(c4_doe_ff);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         c5_ok_ff        <= c4_ok_ff;
         c5_date_only_ff <= c4_date_only_ff;
         c5_days_ok_ff   <= c5_sum >= 22'(SHIFT_TO_1970);
         c5_days_ff      <= c5_sum - 22'(SHIFT_TO_1970);
         c5_tsec_ff      <= c4_tsec_ff;
      end
   end

   always_comb begin
      c6_total = 40'(c5_days_ff) * 40'(SECS_PER_DAY) + 40'(c5_tsec_ff);
      c6_ok_in = c5_ok_ff && c5_days_ok_ff && c6_total[39:32] == 8'd0;
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         c6_ok_ff        <= c6_ok_in;
         c6_date_only_ff <= c5_date_only_ff;
         c6_total_ff     <= c6_total[31:0];
      end
   end

   always_comb begin
      c7_fields_in.epoch     = c6_ok_ff ? c6_total_ff : 32'd0;
      c7_fields_in.date_only = c6_date_only_ff;
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         c7_fields_ff <= c7_fields_in;
      end
   end

   assign fields = c7_fields_ff;

endmodule

// ===== hw/rtl/epoch_civil_date_converter_core.sv =====
// Epoch / civil date converter: accepts one transaction per clock while
// req_ready is high and returns one result per transaction, in order. Each of
// the seven register stages holds at most three reciprocal multiplies of the
// constant divisions. Each stage keeps its own valid bit and loads whenever
// it is empty or the stage after it moves, so bubbles close up under
// backpressure; req_ready follows rsp_ready through that chain in the same
// cycle. Civil-to-epoch results carry 0 in the civil fields and
// epoch-to-civil results carry 0 in epoch_out and date_only. Depends on
// ecdc_pkg, ecdc_e2c, ecdc_c2e and the assertion macro header.
`include "epoch_civil_date_converter_core_assert.svh"

module epoch_civil_date_converter_core
   import ecdc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int unsigned LAST = NUM_STAGES - 1;

   stage_en_type     stage_en;
   stage_en_type     valid_ff, valid_in;
   stage_en_type     valid_shift;
   stage_en_type     kind_ff, kind_in;
   stage_en_type     kind_shift;
   civil_fields_type civil_res;
   epoch_fields_type epoch_res;

   assign stage_en[LAST] = !valid_ff[LAST] || rsp_ready;

   for (genvar k = 0; k < LAST; k++) begin : g_stall
      assign stage_en[k] = !valid_ff[k] || stage_en[k+1];
   end

   assign valid_shift = {valid_ff[LAST-1:0], req_valid};
   assign kind_shift  = {kind_ff[LAST-1:0], req_payload.req_type};
   assign valid_in    = (valid_shift & stage_en) | (valid_ff & ~stage_en);
   assign kind_in     = (kind_shift & stage_en) | (kind_ff & ~stage_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign req_ready = stage_en[0];
   assign rsp_valid = valid_ff[LAST];

   ecdc_e2c u_e2c (
      .clock         (clock),
      .en            (stage_en),
      .epoch_seconds (req_payload.epoch_seconds),
      .fields        (civil_res)
   );

   ecdc_c2e u_c2e (
      .clock  (clock),
      .en     (stage_en),
      .req    (req_payload),
      .fields (epoch_res)
   );

   always_comb begin
      rsp_payload = '0;
      if (kind_ff[LAST] == REQ_CIVIL_TO_EPOCH) begin
         rsp_payload.epoch_out = epoch_res.epoch;
         rsp_payload.date_only = epoch_res.date_only;
      end else begin
         rsp_payload.year_out   = civil_res.year;
         rsp_payload.month_out  = civil_res.month;
         rsp_payload.day_out    = civil_res.day;
         rsp_payload.hour_out   = civil_res.hour;
         rsp_payload.minute_out = civil_res.minute;
         rsp_payload.weekday    = civil_res.weekday;
      end
   end

   `ECDC_ASSERT_NEXT(a_accept_captured, clock, reset, req_valid && req_ready, valid_ff[0], "accepted transaction not captured")
   `ECDC_ASSERT_NEXT(a_stall_holds_result, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(kind_ff[LAST]) && $stable(civil_res) && $stable(epoch_res), "stalled result changed")
   `ECDC_ASSERT_NOW(a_civil_ranges, clock, reset, rsp_valid && kind_ff[LAST] == REQ_EPOCH_TO_CIVIL, rsp_payload.month_out >= 4'd1 && rsp_payload.month_out <= 4'd12 && rsp_payload.day_out >= 5'd1 && rsp_payload.day_out <= 5'd31 && rsp_payload.hour_out <= 5'd23 && rsp_payload.minute_out <= 6'd59 && rsp_payload.weekday <= 3'd6, "civil field out of range")

endmodule
